>>> hdl/string_to_integer_parser_assert.svh
// ----------------------------------------------------------------------------
// String to integer parser assertion macros
// Concurrent assertion shorthands clocked on clk and disabled during rst.
// ----------------------------------------------------------------------------
`ifndef STRING_TO_INTEGER_PARSER_ASSERT_SVH
`define STRING_TO_INTEGER_PARSER_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define STIP_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("string_to_integer_parser: same-cycle check failed");

// Consequent must hold in the cycle after the antecedent.
`define STIP_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("string_to_integer_parser: next-cycle check failed");

`endif

>>> hdl/stip_pkg.sv
// ----------------------------------------------------------------------------
// String to integer parser package
// Widths, character codes, register indexes and shared helper functions.
// ----------------------------------------------------------------------------
package stip_pkg;

  localparam int VALUE_WIDTH = 64;
  localparam int BASE_W      = 6;
  localparam int COUNT_W     = 16;
  localparam int PADDR_W     = 3;
  localparam int PDATA_W     = 32;

  localparam logic [BASE_W-1:0] BASE_RESET = 6'd10;
  localparam logic [BASE_W-1:0] BASE_MAX   = 6'd36;
  localparam logic [BASE_W-1:0] BASE_ONE   = 6'd1;
  localparam logic [BASE_W-1:0] BASE_AUTO  = 6'd0;
  localparam logic [BASE_W-1:0] BASE_OCT   = 6'd8;
  localparam logic [BASE_W-1:0] BASE_DEC   = 6'd10;
  localparam logic [BASE_W-1:0] BASE_HEX   = 6'd16;

  // Register index, taken from paddr[2].
  localparam logic REG_NUMBER_BASE = 1'b0;
  localparam logic REG_SIGNED_MODE = 1'b1;

  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_UC_A  = 8'h41;
  localparam logic [7:0] CH_UC_Z  = 8'h5A;
  localparam logic [7:0] CH_UC_X  = 8'h58;
  localparam logic [7:0] CH_LC_A  = 8'h61;
  localparam logic [7:0] CH_LC_Z  = 8'h7A;
  localparam logic [7:0] CH_LC_X  = 8'h78;

  typedef struct packed {
    logic [BASE_W-1:0] number_base;
    logic              signed_mode;
  } cfg_t;

  typedef struct packed {
    logic              ok;
    logic [BASE_W-1:0] val;
  } digit_t;

  function automatic logic is_blank(input logic [7:0] c);
    return (c == CH_SPACE) || (c >= CH_TAB && c <= CH_CR);
  endfunction

  // Digit value of a character in the widest radix; ok is low for anything
  // that is neither a decimal digit nor a letter.
  function automatic digit_t digit_of(input logic [7:0] c);
    digit_t d;
    d.ok  = 1'b1;
    d.val = '0;
    if (c >= CH_ZERO && c <= CH_NINE) begin
      d.val = BASE_W'(c - CH_ZERO);
    end else if (c >= CH_LC_A && c <= CH_LC_Z) begin
      d.val = BASE_W'(c - CH_LC_A) + BASE_DEC;
    end else if (c >= CH_UC_A && c <= CH_UC_Z) begin
      d.val = BASE_W'(c - CH_UC_A) + BASE_DEC;
    end else begin
      d.ok = 1'b0;
    end
    return d;
  endfunction

endpackage

>>> hdl/string_to_integer_parser.sv
// ----------------------------------------------------------------------------
// String to integer parser
// Streaming strtoul-style converter taking one character per item.
// ----------------------------------------------------------------------------
//
//  Channel  | Handshake             | Payload
//  ---------+-----------------------+------------------------------------------
//  input    | in_valid / in_ready   | start_flag, character
//  output   | out_valid / out_ready | value, consumed_count, status, overflow
//  config   | psel/penable/pwrite   | paddr, pwdata, prdata (pready always 1)
//
// Every accepted item is registered, and from the input register one pass of
// logic (character classification, a VALUE_WIDTH by 6 bit multiply and a
// digit add) updates the parse state. The multiply-add loop through the
// accumulator sets the rate: one item per cycle while the output is not
// stalled. The item ending a string passes the input register, then the
// output register, where out_valid rises and the result waits to be taken.
// Reset (rst, synchronous) returns the parser to idle and loads the radix
// with ten. A stalled result holds the output register; the input register
// then keeps its item and in_ready falls until the result is taken.
//
// A string opens with an item that has start_flag set. Leading white space
// and one sign are taken, then an optional 0 or 0x prefix in auto or hex
// radix, then digits. The first character that does not fit ends the string
// and produces one result item; that character is not counted. An invalid
// radix produces an error result on the starting item itself.
// ----------------------------------------------------------------------------
module string_to_integer_parser
  import stip_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  // input channel
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic                   start_flag,
  input  logic [7:0]             character,
  // output channel
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic [VALUE_WIDTH-1:0] value,
  output logic [COUNT_W-1:0]     consumed_count,
  output logic                   status,
  output logic                   overflow,
  // configuration port
  input  logic                   psel,
  input  logic                   penable,
  input  logic                   pwrite,
  input  logic [PADDR_W-1:0]     paddr,
  input  logic [PDATA_W-1:0]     pwdata,
  output logic [PDATA_W-1:0]     prdata,
  output logic                   pready
);

  localparam int PROD_W = VALUE_WIDTH + BASE_W;

  typedef enum logic [2:0] {
    PH_IDLE,
    PH_SPACE,
    PH_SIGNED,
    PH_ZERO,
    PH_DIGITS
  } phase_t;

  cfg_t cfg;

  stip_apb_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // Input register.
  logic       s1_valid;
  logic       s1_start;
  logic [7:0] s1_char;
  logic       s1_adv;

  // Parse state.
  phase_t                 phase;
  logic                   negative;
  logic [BASE_W-1:0]      active_base;
  logic [VALUE_WIDTH-1:0] accumulator;
  logic [COUNT_W-1:0]     char_count;
  logic                   wrapped;

  phase_t                 phase_next;
  logic                   negative_next;
  logic [BASE_W-1:0]      active_base_next;
  logic [VALUE_WIDTH-1:0] accumulator_next;
  logic [COUNT_W-1:0]     char_count_next;
  logic                   wrapped_next;

  // Per-item decode.
  logic                   done;
  logic                   count_inc;
  logic                   emit;
  logic                   emit_err;
  logic [COUNT_W-1:0]     cnt_base;
  logic [PROD_W-1:0]      mac;
  logic [VALUE_WIDTH-1:0] err_value;
  logic [VALUE_WIDTH-1:0] res_value;
  digit_t                 dig;

  // The input register advances whenever the output register can take a
  // result in the same edge, so the pipeline never loses or repeats an item.
  assign s1_adv   = s1_valid && (!out_valid || out_ready);
  assign in_ready = !s1_valid || s1_adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_start <= start_flag;
      s1_char  <= character;
    end
  end

  assign err_value = cfg.signed_mode ? {1'b0, {(VALUE_WIDTH-1){1'b1}}}
                                     : {VALUE_WIDTH{1'b1}};
  assign dig = digit_of(s1_char);

  // One character through the parse phases. A phase that does not take the
  // character hands it on to the next phase within the same cycle.
  always_comb begin
    phase_next       = phase;
    negative_next    = negative;
    active_base_next = active_base;
    accumulator_next = accumulator;
    cnt_base         = char_count;
    wrapped_next     = wrapped;
    done             = 1'b0;
    count_inc        = 1'b0;
    emit             = 1'b0;
    emit_err         = 1'b0;
    mac              = '0;

    if (s1_start) begin
      negative_next    = 1'b0;
      accumulator_next = '0;
      cnt_base         = '0;
      wrapped_next     = 1'b0;
      active_base_next = cfg.number_base;
      if (cfg.number_base == BASE_ONE || cfg.number_base > BASE_MAX) begin
        emit        = 1'b1;
        emit_err    = 1'b1;
        phase_next  = PH_IDLE;
        done        = 1'b1;
      end else begin
        phase_next = PH_SPACE;
      end
    end

    if (!done && phase_next == PH_IDLE) begin
      done = 1'b1;
    end

    if (!done && phase_next == PH_SPACE) begin
      if (is_blank(s1_char)) begin
        count_inc = 1'b1;
        done      = 1'b1;
      end else if (s1_char == CH_MINUS || s1_char == CH_PLUS) begin
        negative_next = (s1_char == CH_MINUS);
        count_inc     = 1'b1;
        phase_next    = PH_SIGNED;
        done          = 1'b1;
      end else begin
        phase_next = PH_SIGNED;
      end
    end

    if (!done && phase_next == PH_SIGNED) begin
      if (active_base_next == BASE_HEX || active_base_next == BASE_AUTO) begin
        if (s1_char == CH_ZERO) begin
          count_inc = 1'b1;
          if (active_base_next == BASE_AUTO) begin
            active_base_next = BASE_OCT;
          end
          phase_next = PH_ZERO;
          done       = 1'b1;
        end else if (active_base_next == BASE_AUTO) begin
          active_base_next = BASE_DEC;
        end
      end
      if (!done) begin
        phase_next = PH_DIGITS;
      end
    end

    if (!done && phase_next == PH_ZERO) begin
      if (s1_char == CH_LC_X || s1_char == CH_UC_X) begin
        count_inc        = 1'b1;
        active_base_next = BASE_HEX;
        phase_next       = PH_DIGITS;
        done             = 1'b1;
      end else begin
        phase_next = PH_DIGITS;
      end
    end

    if (!done && phase_next == PH_DIGITS) begin
      if (dig.ok && dig.val < active_base_next) begin
        // The sum overflows exactly when any bit above VALUE_WIDTH is set.
        mac = PROD_W'(accumulator_next) * PROD_W'(active_base_next)
            + PROD_W'(dig.val);
        if (mac[PROD_W-1:VALUE_WIDTH] != '0) begin
          wrapped_next = 1'b1;
        end
        accumulator_next = mac[VALUE_WIDTH-1:0];
        count_inc        = 1'b1;
      end else begin
        emit       = 1'b1;
        phase_next = PH_IDLE;
      end
      done = 1'b1;
    end

    char_count_next = cnt_base;
    if (count_inc && cnt_base != {COUNT_W{1'b1}}) begin
      char_count_next = cnt_base + COUNT_W'(1);
    end
  end

  assign res_value = negative_next ? (VALUE_WIDTH'(0) - accumulator_next)
                                   : accumulator_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= PH_IDLE;
      negative    <= 1'b0;
      active_base <= '0;
      accumulator <= '0;
      char_count  <= '0;
      wrapped     <= 1'b0;
    end else if (s1_adv) begin
      phase       <= phase_next;
      negative    <= negative_next;
      active_base <= active_base_next;
      accumulator <= accumulator_next;
      char_count  <= char_count_next;
      wrapped     <= wrapped_next;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_adv && emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv && emit) begin
      if (emit_err) begin
        value          <= err_value;
        consumed_count <= '0;
        status         <= 1'b1;
        overflow       <= 1'b0;
      end else begin
        value          <= res_value;
        consumed_count <= char_count_next;
        status         <= 1'b0;
        overflow       <= wrapped_next;
      end
    end
  end

`include "string_to_integer_parser_assert.svh"

  // An error result never reports consumed characters or a wrap.
  `STIP_ASSERT_IMPL(a_err_clean, out_valid && status, consumed_count == '0 && !overflow)
  // A stalled input register keeps its item.
  `STIP_ASSERT_NEXT(a_s1_hold, s1_valid && !s1_adv, s1_valid && $stable(s1_char) && $stable(s1_start))
  // The parser is idle after every string that produced a result.
  `STIP_ASSERT_NEXT(a_idle_after_emit, s1_adv && emit, phase == PH_IDLE)
  // Back pressure only arises from a held item.
  `STIP_ASSERT_IMPL(a_ready_src, !in_ready, s1_valid && out_valid && !out_ready)
  // A result can only come from an item that left the input register.
  `STIP_ASSERT_NEXT(a_out_src, !out_valid && !(s1_adv && emit), !out_valid)

endmodule

>>> hdl/stip_apb_regs.sv
// ----------------------------------------------------------------------------
// String to integer parser configuration registers
// APB-style slave holding the radix and error-value mode.
// ----------------------------------------------------------------------------
module stip_apb_regs
  import stip_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  output logic [PDATA_W-1:0] prdata,
  output logic               pready,
  output cfg_t               cfg
);

  logic wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.number_base <= BASE_RESET;
      cfg.signed_mode <= 1'b0;
    end else if (wr_en) begin
      unique case (paddr[2])
        REG_NUMBER_BASE: cfg.number_base <= pwdata[BASE_W-1:0];
        REG_SIGNED_MODE: cfg.signed_mode <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      REG_NUMBER_BASE: prdata = PDATA_W'(cfg.number_base);
      REG_SIGNED_MODE: prdata = PDATA_W'(cfg.signed_mode);
      default:         prdata = '0;
    endcase
  end

endmodule

>>> verif/tb_string_to_integer_parser.sv
// ----------------------------------------------------------------------------
// String to integer parser testbench
// Streams character items into the parser and predicts each conversion with
// a behavioral copy of the parse state. Directed strings cover white space,
// signs, radix prefixes, restarts and bad radix values. Random number strings
// then run under three stall mixes, with both configuration registers written
// between phases while the parser is idle.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_string_to_integer_parser;
  import stip_pkg::*;

  // Watchdog limit, ample for the slowest legal run.
  localparam int CYCLE_LIMIT = 500_000;
  // An item passes the input and output registers on its way to a result, so
  // SETTLE_CYCLES spare cycles are enough to be sure the parser has gone quiet.
  localparam int SETTLE_CYCLES = 4;
  localparam logic [VALUE_WIDTH-1:0] VALUE_ALL_ONES = '1;

  typedef enum logic [2:0] {
    SCAN_IDLE,
    SCAN_BLANK,
    SCAN_SIGNED,
    SCAN_ZERO,
    SCAN_DIGITS
  } scan_phase_t;

  typedef struct packed {
    logic [VALUE_WIDTH-1:0] value;
    logic [COUNT_W-1:0]     count;
    logic                   status;
    logic                   overflow;
  } conversion_t;

  logic                   clk;
  logic                   rst            = 1'b1;
  logic                   in_valid       = 1'b0;
  logic                   in_ready;
  logic                   start_flag     = 1'b0;
  logic [7:0]             character      = 8'h00;
  logic                   out_valid;
  logic                   out_ready      = 1'b1;
  logic [VALUE_WIDTH-1:0] value;
  logic [COUNT_W-1:0]     consumed_count;
  logic                   status;
  logic                   overflow;
  logic                   psel           = 1'b0;
  logic                   penable        = 1'b0;
  logic                   pwrite         = 1'b0;
  logic [PADDR_W-1:0]     paddr          = '0;
  logic [PDATA_W-1:0]     pwdata         = '0;
  logic [PDATA_W-1:0]     prdata;
  logic                   pready;

  string_to_integer_parser u_top (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .start_flag     (start_flag),
    .character      (character),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .value          (value),
    .consumed_count (consumed_count),
    .status         (status),
    .overflow       (overflow),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready)
  );

  // Predicted parse state and the register copies that it reads.
  scan_phase_t            conv_phase    = SCAN_IDLE;
  logic                   conv_negative = 1'b0;
  logic [BASE_W-1:0]      conv_base     = '0;
  logic [VALUE_WIDTH-1:0] conv_acc      = '0;
  logic [COUNT_W-1:0]     conv_count    = '0;
  logic                   conv_wrapped  = 1'b0;
  logic [BASE_W-1:0]      cfg_base      = BASE_RESET;
  logic                   cfg_signed    = 1'b0;

  // Conversions predicted but not yet seen on the output, oldest first.
  conversion_t pending_results[$];

  int send_idle_pct   = 0;
  int recv_idle_pct   = 0;
  int items_parsed    = 0;
  int items_ignored   = 0;
  int results_checked = 0;
  int overflow_seen   = 0;
  int bad_radix_seen  = 0;
  int fail_count      = 0;
  int cycle_count     = 0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Watchdog: a hung handshake ends the run here.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles with %0d results outstanding.",
               cycle_count, pending_results.size());
      $display("TB_ERROR");
      $finish;
    end
  end

  // The receiver stalls at random with the probability of the current mix.
  always @(posedge clk) begin
    out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
  end

  // Saturating count of the characters that a string has consumed.
  function automatic void count_taken();
    if (conv_count != '1) begin
      conv_count = conv_count + 1'b1;
    end
  endfunction

  // Advances the predicted state by one accepted item. Returns 1 when the
  // item ends a string, with the conversion in res.
  function automatic bit convert_char(input logic start, input logic [7:0] ch,
                                      output conversion_t res);
    logic              is_digit;
    logic [BASE_W-1:0] digit;
    logic [VALUE_WIDTH-1:0] radix;
    res = '0;
    if (start) begin
      conv_negative = 1'b0;
      conv_acc      = '0;
      conv_count    = '0;
      conv_wrapped  = 1'b0;
      conv_base     = cfg_base;
      // A bad radix answers on the starting item with the error value.
      if (cfg_base == BASE_ONE || cfg_base > BASE_MAX) begin
        res.value  = cfg_signed ? (VALUE_ALL_ONES >> 1) : VALUE_ALL_ONES;
        res.status = 1'b1;
        conv_phase = SCAN_IDLE;
        return 1'b1;
      end
      conv_phase = SCAN_BLANK;
    end
    if (conv_phase == SCAN_IDLE) begin
      return 1'b0;
    end
    if (conv_phase == SCAN_BLANK) begin
      if (ch == CH_SPACE || (ch >= CH_TAB && ch <= CH_CR)) begin
        count_taken();
        return 1'b0;
      end
      if (ch == CH_MINUS || ch == CH_PLUS) begin
        conv_negative = (ch == CH_MINUS);
        count_taken();
        conv_phase = SCAN_SIGNED;
        return 1'b0;
      end
      conv_phase = SCAN_SIGNED;
    end
    if (conv_phase == SCAN_SIGNED) begin
      // Auto and hex radix both look for a leading zero.
      if (conv_base == BASE_HEX || conv_base == BASE_AUTO) begin
        if (ch == CH_ZERO) begin
          count_taken();
          if (conv_base == BASE_AUTO) begin
            conv_base = BASE_OCT;
          end
          conv_phase = SCAN_ZERO;
          return 1'b0;
        end
        if (conv_base == BASE_AUTO) begin
          conv_base = BASE_DEC;
        end
      end
      conv_phase = SCAN_DIGITS;
    end
    if (conv_phase == SCAN_ZERO) begin
      if (ch == CH_LC_X || ch == CH_UC_X) begin
        count_taken();
        conv_base  = BASE_HEX;
        conv_phase = SCAN_DIGITS;
        return 1'b0;
      end
      conv_phase = SCAN_DIGITS;
    end
    // Digit phase: letters of either case count from ten upward.
    is_digit = 1'b1;
    digit    = '0;
    if (ch >= CH_ZERO && ch <= CH_NINE) begin
      digit = BASE_W'(ch - CH_ZERO);
    end else if (ch >= CH_LC_A && ch <= CH_LC_Z) begin
      digit = BASE_W'(ch - CH_LC_A) + BASE_DEC;
    end else if (ch >= CH_UC_A && ch <= CH_UC_Z) begin
      digit = BASE_W'(ch - CH_UC_A) + BASE_DEC;
    end else begin
      is_digit = 1'b0;
    end
    if (is_digit && digit < conv_base) begin
      radix = VALUE_WIDTH'(conv_base);
      if (conv_acc > (VALUE_ALL_ONES - VALUE_WIDTH'(digit)) / radix) begin
        conv_wrapped = 1'b1;
      end
      conv_acc = conv_acc * radix + VALUE_WIDTH'(digit);
      count_taken();
      return 1'b0;
    end
    // Anything else ends the string without being counted.
    res.value    = conv_negative ? (VALUE_WIDTH'(0) - conv_acc) : conv_acc;
    res.count    = conv_count;
    res.overflow = conv_wrapped;
    conv_phase   = SCAN_IDLE;
    return 1'b1;
  endfunction

  // Sends one item, with a random idle gap in front of it, and records the
  // conversion that it completes.
  task automatic send_char(input logic start, input logic [7:0] ch);
    conversion_t res;
    if ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(0, 99) < send_idle_pct);
    end
    in_valid   <= 1'b1;
    start_flag <= start;
    character  <= ch;
    do @(posedge clk); while (!in_ready);
    if (!start && conv_phase == SCAN_IDLE) begin
      items_ignored++;
    end else begin
      items_parsed++;
    end
    if (convert_char(start, ch, res)) begin
      pending_results.push_back(res);
    end
  endtask

  // Sends a string, the first character opening it, with an optional
  // terminating zero.
  task automatic send_string(input string s, input bit terminate);
    for (int i = 0; i < s.len(); i++) begin
      send_char(i == 0, s[i]);
    end
    if (terminate) begin
      send_char(1'b0, 8'h00);
    end
  endtask

  // Closes any open string, then holds the input off until every expected
  // result has come and the pipeline has emptied.
  task automatic settle_parser();
    if (conv_phase != SCAN_IDLE) begin
      send_char(1'b0, 8'h00);
    end
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic apb_write(input logic reg_sel, input logic [PDATA_W-1:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= PADDR_W'({reg_sel, 2'b00});
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  // Registers are only written with the parser idle.
  task automatic program_parser(input logic [BASE_W-1:0] base, input logic sgn);
    settle_parser();
    apb_write(REG_NUMBER_BASE, PDATA_W'(base));
    apb_write(REG_SIGNED_MODE, PDATA_W'(sgn));
    cfg_base   = base;
    cfg_signed = sgn;
  endtask

  // Builds one well-formed number string for the current radix with random
  // white space, sign, prefix, digits and terminator, and sends it.
  task automatic send_number();
    logic [7:0] chars[$];
    int digit_base;
    int n_digits;
    int d;
    int pick;
    digit_base = (cfg_base == BASE_AUTO) ? 10 : int'(cfg_base);
    repeat (($urandom_range(0, 3) == 0) ? $urandom_range(1, 3) : 0) begin
      pick = $urandom_range(0, 5);
      chars.push_back((pick == 5) ? CH_SPACE : CH_TAB + 8'(pick));
    end
    case ($urandom_range(0, 3))
      0: begin
        chars.push_back(CH_PLUS);
      end
      1: begin
        chars.push_back(CH_MINUS);
      end
      default: begin
      end
    endcase
    if (cfg_base == BASE_AUTO) begin
      case ($urandom_range(0, 2))
        0: begin
          chars.push_back(CH_ZERO);
          digit_base = 8;
        end
        1: begin
          chars.push_back(CH_ZERO);
          chars.push_back($urandom_range(0, 1) ? CH_LC_X : CH_UC_X);
          digit_base = 16;
        end
        default: begin
        end
      endcase
    end else if (cfg_base == BASE_HEX && $urandom_range(0, 1)) begin
      chars.push_back(CH_ZERO);
      chars.push_back($urandom_range(0, 1) ? CH_LC_X : CH_UC_X);
    end
    // Mostly short numbers; some long enough to wrap even in radix 2.
    pick = $urandom_range(0, 99);
    if (pick < 70) begin
      n_digits = $urandom_range(0, 8);
    end else if (pick < 95) begin
      n_digits = $urandom_range(9, 20);
    end else begin
      n_digits = $urandom_range(21, 70);
    end
    repeat (n_digits) begin
      d = $urandom_range(0, digit_base - 1);
      if (d < 10) begin
        chars.push_back(CH_ZERO + 8'(d));
      end else begin
        chars.push_back(($urandom_range(0, 1) ? CH_LC_A : CH_UC_A) + 8'(d - 10));
      end
    end
    // Usually a zero ends the string, sometimes any byte, and sometimes the
    // next start abandons it.
    pick = $urandom_range(0, 9);
    if (pick >= 1 && pick <= 5) begin
      chars.push_back(8'h00);
    end else if (pick > 5) begin
      chars.push_back(8'($urandom_range(0, 255)));
    end
    if (chars.size() == 0) begin
      chars.push_back(8'h00);
    end
    foreach (chars[i]) begin
      send_char(i == 0, chars[i]);
    end
  endtask

  // Result checker: every handshake on the output must match the oldest
  // prediction field by field.
  always @(posedge clk) begin
    conversion_t want;
    if (!rst && out_valid && out_ready) begin
      results_checked++;
      if (overflow === 1'b1) begin
        overflow_seen++;
      end
      if (status === 1'b1) begin
        bad_radix_seen++;
      end
      if (pending_results.size() == 0) begin
        fail_count++;
        if (fail_count <= 10) begin
          $display("Unexpected result: value=%h count=%0d status=%b overflow=%b",
                   value, consumed_count, status, overflow);
        end
      end else begin
        want = pending_results.pop_front();
        if (value !== want.value || consumed_count !== want.count ||
            status !== want.status || overflow !== want.overflow) begin
          fail_count++;
          if (fail_count <= 10) begin
            $display("Mismatch on result %0d:", results_checked);
            $display("  expected value=%h count=%0d status=%b overflow=%b",
                     want.value, want.count, want.status, want.overflow);
            $display("  actual   value=%h count=%0d status=%b overflow=%b",
                     value, consumed_count, status, overflow);
          end
        end
      end
    end
  end

  // Decimal at the reset radix: an item with no string open, white space
  // and a minus sign, and strings that end on their first character.
  task automatic test_decimal_basics();
    send_char(1'b0, "5");
    send_string(" -42", 1'b1);
    send_char(1'b1, 8'hFF);
    send_char(1'b1, 8'h00);
  endtask

  // A start in mid-string drops the open string without a result.
  task automatic test_restart();
    send_string("12", 1'b0);
    send_string("+7z", 1'b0);
  endtask

  // Auto radix: hex prefix with no digits, octal stopped by an 8, decimal.
  task automatic test_auto_radix();
    program_parser(BASE_AUTO, 1'b0);
    send_string("0xg", 1'b0);
    send_string("078", 1'b0);
    send_string("19", 1'b1);
  endtask

  // Radix 16 skips an uppercase prefix; letters of both cases are digits.
  task automatic test_hex_prefix();
    program_parser(BASE_HEX, 1'b0);
    send_string("0XfF", 1'b1);
  endtask

  // Widest radix with a tab and a negative result.
  task automatic test_radix_36();
    program_parser(BASE_MAX, 1'b0);
    send_string("\t-zZ", 1'b1);
  endtask

  // Bad radix values give the error value in both modes on the start item.
  task automatic test_bad_radix();
    program_parser(BASE_ONE, 1'b0);
    send_char(1'b1, "a");
    send_char(1'b0, "1");
    program_parser(6'd63, 1'b1);
    send_char(1'b1, 8'h00);
  endtask

  // Random phases, each with a fresh register setting. Bad radix phases
  // are kept short since every start item ends at once.
  task automatic test_random_streams(input int send_pct, input int recv_pct,
                                     input int goal);
    int stop_at;
    int phase_end;
    logic [BASE_W-1:0] base_pick;
    bit bad_base;
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
    stop_at = items_parsed + goal;
    while (items_parsed < stop_at) begin
      case ($urandom_range(0, 11))
        0: base_pick = BASE_AUTO;
        1: base_pick = 6'd2;
        2: base_pick = BASE_MAX;
        3: base_pick = BASE_HEX;
        4: base_pick = BASE_OCT;
        5: base_pick = BASE_DEC;
        6: base_pick = BASE_ONE;
        7: base_pick = 6'd63;
        8: base_pick = BASE_W'($urandom_range(37, 62));
        default: base_pick = BASE_W'($urandom_range(2, 36));
      endcase
      bad_base = (base_pick == BASE_ONE || base_pick > BASE_MAX);
      program_parser(base_pick, 1'($urandom_range(0, 1)));
      phase_end = items_parsed + (bad_base ? 12 : $urandom_range(40, 110));
      while (items_parsed < phase_end && items_parsed < stop_at) begin
        if (bad_base) begin
          send_char(1'b1, 8'($urandom_range(0, 255)));
          if ($urandom_range(0, 2) == 0) begin
            send_char(1'b0, 8'($urandom_range(0, 255)));
          end
        end else if ($urandom_range(0, 99) < 8) begin
          // Noise: arbitrary bytes, now and then restarting a string.
          send_char($urandom_range(0, 9) == 0, 8'($urandom_range(0, 255)));
        end else begin
          send_number();
        end
      end
    end
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_decimal_basics();
    test_restart();
    test_auto_radix();
    test_hex_prefix();
    test_radix_36();
    test_bad_radix();
    test_random_streams(17, 82, 430);
    test_random_streams(82, 17, 430);
    test_random_streams(0, 0, 430);

    settle_parser();
    if (pending_results.size() != 0) begin
      fail_count += pending_results.size();
    end

    $display("Run summary: %0d characters parsed, %0d ignored, %0d results checked.",
             items_parsed, items_ignored, results_checked);
    $display("Results with wrap: %0d, with bad radix: %0d, failures: %0d.",
             overflow_seen, bad_radix_seen, fail_count);
    if (fail_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
